FILE: rtl/core/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta list timer queue: opcodes, result
// kinds, read address selects and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package dltq_pkg;

   localparam int DELTA_BITS = 32;
   localparam int KIND_BITS  = 2;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INSERT_OK = 2'd0,
      KIND_FULL      = 2'd1,
      KIND_EXPIRED   = 2'd2,
      KIND_NO_EXPIRY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      RD_HEAD,
      RD_NEXT_HEAD,
      RD_WALK,
      RD_TAIL,
      RD_SHIFT
   } rd_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SHIFT,
      ST_PLACE,
      ST_REJECT,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic       start_ins;
      logic       start_tick;
      rd_sel_type rd_sel;
      logic       walk_step;
      logic       walk_found;
      logic       shift_step;
      logic       place;
      logic       expire;
      logic       decr;
      logic       emit;
      kind_type   emit_kind;
      logic       emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic walk_hit;
      logic walk_end;
      logic shift_done;
      logic tick_expire;
      logic count_one;
      logic pend;
      logic left;
   } dp_status_type;

endpackage

FILE: rtl/core/dltq_ram.sv
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dltq_datapath.sv
// ----------------------------------------------------------------------------
// dltq_datapath
// Circular entry store, insert walk and shift registers, tick bookkeeping and
// the result word register.
// ----------------------------------------------------------------------------
module dltq_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              req_duration_ms,
   input  logic [TAG_BITS-1:0]      req_tag,
   input  dltq_pkg::dp_cmd_type     cmd,
   output dltq_pkg::dp_status_type  status,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_kind,
   output logic [TAG_BITS-1:0]      rsp_expired_tag,
   output logic                     rsp_last
);

   import dltq_pkg::*;

   localparam int IW     = $clog2(QUEUE_DEPTH);
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int SW     = CW + 1;
   localparam int DATA_W = DELTA_BITS + TAG_BITS;

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DELTA_BITS-1:0] rem_ff, rem_in;
   logic [TAG_BITS-1:0]   new_tag_ff, new_tag_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         shift_ff, shift_in;
   logic                  left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [TAG_BITS-1:0]   pend_tag_ff, pend_tag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic [IW-1:0]         rd_addr;
   logic [DATA_W-1:0]     rd_data;
   logic [DELTA_BITS-1:0] rd_delta;
   logic [TAG_BITS-1:0]   rd_tag;
   logic [DELTA_BITS-1:0] shift_delta;
   logic                  out_free;

   dltq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_delta = rd_data[DATA_W-1 -: DELTA_BITS];
   assign rd_tag   = rd_data[TAG_BITS-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD:      rd_addr = head_ff;
         RD_NEXT_HEAD: rd_addr = phys(head_ff, CW'(1));
         RD_WALK:      rd_addr = phys(head_ff, CW'(idx_ff + 1'b1));
         RD_TAIL:      rd_addr = phys(head_ff, CW'(count_ff - 1'b1));
         RD_SHIFT:     rd_addr = phys(head_ff, CW'(shift_ff - 1'b1));
         default:      rd_addr = head_ff;
      endcase
   end

   // entry at the insert point moves up with its delta reduced by the new entry's remaining delay
   assign shift_delta = (shift_ff == pos_ff) ? rd_delta - rem_ff : rd_delta;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = rd_data;
      if (cmd.shift_step) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, CW'(shift_ff + 1'b1));
         wr_data = {shift_delta, rd_tag};
      end else if (cmd.place) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, pos_ff);
         wr_data = {rem_ff, new_tag_ff};
      end else if (cmd.decr) begin
         wr_en   = 1'b1;
         wr_addr = head_ff;
         wr_data = {rd_delta - DELTA_BITS'(1), rd_tag};
      end
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      new_tag_in   = new_tag_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_tag_in  = pend_tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.start_ins) begin
         rem_in     = req_duration_ms;
         new_tag_in = req_tag;
         idx_in     = '0;
         pos_in     = count_ff;
      end
      if (cmd.walk_step) begin
         rem_in = rem_ff - rd_delta;
         idx_in = CW'(idx_ff + 1'b1);
      end
      if (cmd.walk_found) begin
         pos_in   = idx_ff;
         shift_in = CW'(count_ff - 1'b1);
      end
      if (cmd.shift_step) begin
         shift_in = CW'(shift_ff - 1'b1);
      end
      if (cmd.place) begin
         count_in = CW'(count_ff + 1'b1);
      end
      if (cmd.start_tick) begin
         left_in = 1'b1;
         pend_in = 1'b0;
      end
      if (cmd.expire) begin
         pend_in     = 1'b1;
         pend_tag_in = rd_tag;
         head_in     = phys(head_ff, CW'(1));
         count_in    = CW'(count_ff - 1'b1);
         left_in     = left_ff && (rd_delta == '0);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.emit_kind;
         rsp_tag_in   = (cmd.emit_kind == KIND_EXPIRED) ? pend_tag_ff : '0;
         rsp_last_in  = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      new_tag_ff  <= new_tag_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      shift_ff    <= shift_in;
      pend_tag_ff <= pend_tag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.full        = (count_ff == CW'(QUEUE_DEPTH));
      status.empty       = (count_ff == '0);
      status.out_free    = out_free;
      status.walk_hit    = (rem_ff == '0) || (rem_ff < rd_delta);
      status.walk_end    = (CW'(idx_ff + 1'b1) == count_ff);
      status.shift_done  = (shift_ff == pos_ff);
      status.tick_expire = (rd_delta == '0) || (left_ff && (rd_delta == DELTA_BITS'(1)));
      status.count_one   = (count_ff == CW'(1));
      status.pend        = pend_ff;
      status.left        = left_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_expired_tag = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> count_ff < CW'(QUEUE_DEPTH))
      else $error("insert placed into full queue");

   a_expire_count: assert property (@(posedge clock) disable iff (reset)
      cmd.expire |=> count_ff == CW'($past(count_ff) - 1'b1))
      else $error("expiry did not drop entry count");

   a_tag_only_on_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != KIND_EXPIRED) |-> rsp_tag_ff == '0)
      else $error("tag reported on non-expiry word");

   a_emit_space: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result word overwritten while stalled");

endmodule

FILE: rtl/core/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for insert walks, shifts and tick expiry; drives datapath commands.
// ----------------------------------------------------------------------------
module dltq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   output logic                    req_stall,
   input  dltq_pkg::dp_status_type status,
   output dltq_pkg::dp_cmd_type    cmd
);

   import dltq_pkg::*;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_tick;

   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign is_tick = (opcode_type'(req_opcode) == OP_TICK);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_tick) begin
                  state_in = status.empty ? ST_FLUSH : ST_EVAL;
               end else if (status.full) begin
                  state_in = ST_REJECT;
               end else begin
                  state_in = status.empty ? ST_PLACE : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.walk_hit) begin
               state_in = ST_SHIFT;
            end else if (status.walk_end) begin
               state_in = ST_PLACE;
            end
         end
         ST_SHIFT: begin
            if (status.shift_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE, ST_REJECT, ST_FLUSH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EVAL: begin
            if (!status.tick_expire) begin
               state_in = ST_FLUSH;
            end else if ((!status.pend || status.out_free) && status.count_one) begin
               state_in = ST_FLUSH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = RD_HEAD;
      cmd.emit_kind = KIND_INSERT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.start_ins  = accept && !is_tick;
            cmd.start_tick = accept && is_tick;
         end
         ST_WALK: begin
            if (status.walk_hit) begin
               cmd.walk_found = 1'b1;
               cmd.rd_sel     = RD_TAIL;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.rd_sel    = RD_WALK;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            cmd.rd_sel     = status.shift_done ? RD_HEAD : RD_SHIFT;
         end
         ST_PLACE: begin
            cmd.place     = status.out_free;
            cmd.emit      = status.out_free;
            cmd.emit_kind = KIND_INSERT_OK;
            cmd.emit_last = 1'b1;
         end
         ST_REJECT: begin
            cmd.emit      = status.out_free;
            cmd.emit_kind = KIND_FULL;
            cmd.emit_last = 1'b1;
         end
         ST_EVAL: begin
            if (status.tick_expire) begin
               if (!status.pend || status.out_free) begin
                  cmd.expire    = 1'b1;
                  cmd.emit      = status.pend;
                  cmd.emit_kind = KIND_EXPIRED;
                  cmd.rd_sel    = RD_NEXT_HEAD;
               end
            end else begin
               cmd.decr = status.left;
            end
         end
         ST_FLUSH: begin
            cmd.emit      = status.out_free;
            cmd.emit_kind = status.pend ? KIND_EXPIRED : KIND_NO_EXPIRY;
            cmd.emit_last = 1'b1;
         end
         default: cmd.rd_sel = RD_HEAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && !status.walk_hit && status.walk_end |=> state_ff == ST_PLACE)
      else $error("walk past tail");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_last |=> state_ff == ST_IDLE)
      else $error("final word did not end the item");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(cmd.place || cmd.shift_step || cmd.decr || cmd.expire))
      else $error("store changed while idle");

endmodule

FILE: rtl/core/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Timer queue held as a sorted delta list in a circular RAM of QUEUE_DEPTH
// entries. One item is worked at a time; req_stall is high while it runs.
// An insert runs through the accepting cycle, a walk over the entries to find
// the insert point, a shift up of each entry behind it when it lands in front
// of an existing entry, and the write of the new entry, all set by the single
// read and write port of the entry RAM. A tick reads and retires the head
// one expired timer at a time. Each result word sits in an output register,
// so a new item is accepted while the last word of the previous one still
// waits on rsp_stall; any further word waits there too and adds its stall
// cycles.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [31:0]         req_duration_ms,
   input  logic [TAG_BITS-1:0] req_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [TAG_BITS-1:0] rsp_expired_tag,
   output logic                rsp_last
);

   import dltq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   dltq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   dltq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_duration_ms (req_duration_ms),
      .req_tag         (req_tag),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_expired_tag (rsp_expired_tag),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: dv/delta_list_timer_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core_tb
// Self-checking bench for the delta list timer queue. A directed table covers
// an empty tick, zero, equal and maximum delays, a full queue and the reject.
// Random inserts and ticks follow, biased in turns toward filling and
// draining. An in-bench delta list predicts each result word that the table
// does not give, and each word is checked in order. Both sides idle and stall
// at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core_tb;
   import dltq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TAG_BITS     = 8;
   localparam int DIR_ROWS     = 25;
   localparam int RANDOM_WORDS = 85;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      kind_type            kind;
      logic [TAG_BITS-1:0] tag;
      logic                last;
   } result_word_type;

   typedef struct packed {
      opcode_type          op;
      logic [31:0]         dur;
      logic [TAG_BITS-1:0] tag;
      logic                typed;
      result_word_type     word;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = 1'b0;
   logic [31:0]         req_duration_ms = '0;
   logic [TAG_BITS-1:0] req_tag = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_kind;
   logic [TAG_BITS-1:0] rsp_expired_tag;
   logic                rsp_last;

   // predicted delta list
   logic [31:0]         timer_delta [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] timer_tag   [QUEUE_DEPTH];
   int                  timer_count = 0;

   result_word_type step_words [$];
   result_word_type pending_words [$];

   int errors        = 0;
   int cycle_count   = 0;
   int send_idle_pct = 20;
   int rcv_stall_pct = 52;
   bit hold_req      = 1'b0;
   int hold_left     = 0;

   localparam result_word_type NO_WORD = '{KIND_INSERT_OK, '0, 1'b0};
   localparam result_word_type OK_WORD = '{KIND_INSERT_OK, '0, 1'b1};

   stim_row_type dir_rows [DIR_ROWS] = '{
      '{OP_TICK,   32'd0,          8'h00, 1'b1, '{KIND_NO_EXPIRY, 8'h00, 1'b1}},
      '{OP_INSERT, 32'd0,          8'hFF, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd2,          8'h01, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd2,          8'h02, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd0,          8'h03, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd1,          8'h04, 1'b1, OK_WORD},
      '{OP_TICK,   32'hFFFF_FFFF,  8'hFF, 1'b0, NO_WORD},
      '{OP_TICK,   32'd0,          8'h00, 1'b0, NO_WORD},
      '{OP_INSERT, 32'hFFFF_FFFF,  8'hAA, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd1,          8'h00, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd5,          8'h55, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd3,          8'h11, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd5,          8'h22, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd0,          8'h33, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd2,          8'h44, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd7,          8'h66, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd3,          8'h77, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd1,          8'h88, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd9,          8'h99, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd4,          8'hBB, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd6,          8'hCC, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd2,          8'hDD, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd8,          8'hEE, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd5,          8'h0F, 1'b1, OK_WORD},
      '{OP_INSERT, 32'd3,          8'hF0, 1'b1, '{KIND_FULL, 8'h00, 1'b1}}
   };

   delta_list_timer_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_duration_ms(req_duration_ms),
      .req_tag        (req_tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_expired_tag(rsp_expired_tag),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Advance the delta list by one word; results land in step_words.
   task automatic advance_timers(input opcode_type op, input logic [31:0] dur,
                                 input logic [TAG_BITS-1:0] tg);
      logic [31:0]     rem;
      logic [31:0]     left;
      logic [31:0]     diff;
      int              pos;
      int              i;
      bit              found;
      bit              stop;
      result_word_type w;
      step_words.delete();
      if (op == OP_INSERT) begin
         if (timer_count >= QUEUE_DEPTH) begin
            step_words.push_back('{KIND_FULL, '0, 1'b0});
         end else begin
            rem   = dur;
            pos   = timer_count;
            found = 1'b0;
            for (i = 0; i < timer_count && !found; i++) begin
               if (rem == 0 || rem < timer_delta[i]) begin
                  timer_delta[i] = timer_delta[i] - rem;
                  pos   = i;
                  found = 1'b1;
               end else begin
                  rem = rem - timer_delta[i];
               end
            end
            for (i = timer_count; i > pos; i--) begin
               timer_delta[i] = timer_delta[i-1];
               timer_tag[i]   = timer_tag[i-1];
            end
            timer_delta[pos] = rem;
            timer_tag[pos]   = tg;
            timer_count++;
            step_words.push_back('{KIND_INSERT_OK, '0, 1'b0});
         end
      end else begin
         left = 32'd1;
         stop = 1'b0;
         while (timer_count > 0 && !stop) begin
            diff = (timer_delta[0] < left) ? timer_delta[0] : left;
            timer_delta[0] = timer_delta[0] - diff;
            left = left - diff;
            if (timer_delta[0] != 0) begin
               stop = 1'b1;
            end else begin
               step_words.push_back('{KIND_EXPIRED, timer_tag[0], 1'b0});
               for (i = 0; i < timer_count - 1; i++) begin
                  timer_delta[i] = timer_delta[i+1];
                  timer_tag[i]   = timer_tag[i+1];
               end
               timer_count--;
            end
         end
         if (step_words.size() == 0)
            step_words.push_back('{KIND_NO_EXPIRY, '0, 1'b0});
      end
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
   endtask

   task automatic send_word(input opcode_type op, input logic [31:0] dur,
                            input logic [TAG_BITS-1:0] tg, input logic typed,
                            input result_word_type typed_word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_duration_ms <= dur;
      req_tag         <= tg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_timers(op, dur, tg);
      if (typed) begin
         pending_words.push_back(typed_word);
      end else begin
         foreach (step_words[j]) pending_words.push_back(step_words[j]);
      end
   endtask

   // receiver stall, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      result_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word: kind %0d tag %0h last %0b",
                   rsp_kind, rsp_expired_tag, rsp_last);
            errors++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_kind !== w.kind) begin
               $error("kind: expected %0d, got %0d", w.kind, rsp_kind);
               errors++;
            end
            if (rsp_expired_tag !== w.tag) begin
               $error("expired_tag: expected %0h, got %0h", w.tag, rsp_expired_tag);
               errors++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0b, got %0b", w.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int                  k;
      int                  ins_pct;
      opcode_type          op;
      logic [31:0]         dur;
      logic [TAG_BITS-1:0] tg;
      ins_pct = 75;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++)
         send_word(dir_rows[k].op, dir_rows[k].dur, dir_rows[k].tag,
                   dir_rows[k].typed, dir_rows[k].word);

      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k == RANDOM_WORDS / 3) begin
            send_idle_pct = 52;
            rcv_stall_pct = 20;
         end
         if (k == 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
            hold_req      = 1'b1;
         end
         // pick a fill or drain bias at random for each stretch of 16 items
         if (k % 16 == 0)
            ins_pct = ($urandom_range(1) == 0) ? 80 : 30;
         op  = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_TICK;
         dur = ($urandom_range(24) == 0) ? $urandom() : $urandom_range(12);
         tg  = TAG_BITS'($urandom_range(2**TAG_BITS - 1));
         send_word(op, dur, tg, 1'b0, NO_WORD);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
